>>> sv/cmc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the colour matrix converter.
package cmc_pkg;

    // Fraction bits of the matrix coefficients (S3.14 by default, 10 to 16 allowed).
    localparam int COEF_FRAC_BITS = 14;

    localparam int COEF_W   = 18;                    // one signed coefficient
    localparam int ROW_W    = 3 * COEF_W;            // packed coefficient row
    localparam int PIX_W    = 16;                    // component port width
    localparam int COMP_W   = 24;                    // internal component scale
    localparam int DIFF_W   = COMP_W + 1;            // component minus zero point
    localparam int PROD_W   = COEF_W + DIFF_W;       // full product
    localparam int QUOT_W   = PROD_W - COEF_FRAC_BITS; // product with fraction dropped
    localparam int SUM_W    = QUOT_W + 3;            // three products plus zero point
    localparam int CFG_IDX_W = 3;

    localparam logic [COMP_W-1:0] LIM_MIN        = 24'h100000;
    localparam logic [COMP_W-1:0] LIM_MAX_LUMA   = 24'hebffff;
    localparam logic [COMP_W-1:0] LIM_MAX_CHROMA = 24'hf0ffff;
    localparam logic [COMP_W-1:0] FULL_MAX       = 24'hffffff;
    localparam logic [COMP_W-1:0] CHROMA_ZERO    = 24'h800000;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);

    typedef logic signed [DIFF_W-1:0] cmc_diff_t;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_ROW0       = 3'd0,
        REG_COEF_ROW1       = 3'd1,
        REG_COEF_ROW2       = 3'd2,
        REG_IN_LIMITED      = 3'd3,
        REG_OUT_LIMITED     = 3'd4,
        REG_IN_CENTERED     = 3'd5,
        REG_OUT_CENTERED    = 3'd6,
        REG_WIDE_COMPONENTS = 3'd7
    } cmc_reg_idx_t;

    // Mode bits shared by the input conditioner and the matrix rows.
    typedef struct packed {
        logic in_limited;
        logic out_limited;
        logic in_centered;
        logic out_centered;
        logic wide;
    } cmc_mode_t;

    function automatic logic [COMP_W-1:0] range_min(input logic limited);
        return limited ? LIM_MIN : '0;
    endfunction

    function automatic logic [COMP_W-1:0] range_max(input logic limited, input logic luma);
        if (!limited) begin
            return FULL_MAX;
        end
        return luma ? LIM_MAX_LUMA : LIM_MAX_CHROMA;
    endfunction

    function automatic logic [COMP_W-1:0] zero_point(input logic limited,
                                                     input logic centered,
                                                     input logic luma);
        return (!luma && centered) ? CHROMA_ZERO : range_min(limited);
    endfunction

endpackage

>>> sv/color_matrix_converter.sv
`timescale 1ns / 1ps
// Top level of the colour matrix converter: config registers, pipeline and control.
//
// Converts one pixel of three components per word through a 3x3 S3.14
// matrix between colour spaces and value ranges.
// Input channel (s_*): one pixel word per handshake, taken when s_valid and
//   s_ready are both high. Result channel (m_*): one converted pixel word per
//   input word, in order.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr at the clock
//   edge, no wait states. Change settings only while the block is empty.
// Pipeline: an input register and a result register with the whole conversion
//   in between. A word taken passes through the input register, then the result
//   register, to m_*; throughput is one word per cycle while m_ready stays high.
// s_ready stays high while the input register is empty or moving on, so a
//   new word is taken even while a finished result waits on m_*.
// When the receiver stalls, the result holds on m_*, one more word parks in
//   the input register, then s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both stages and loads the identity
//   matrix, full range, uncentred chroma and 8-bit components.
module color_matrix_converter
    import cmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [ROW_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_in_c0,
    input  logic [PIX_W-1:0]     s_in_c1,
    input  logic [PIX_W-1:0]     s_in_c2,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_out_c0,
    output logic [PIX_W-1:0]     m_out_c1,
    output logic [PIX_W-1:0]     m_out_c2
);

    // Configuration registers.
    logic [ROW_W-1:0] coef_row0_reg;
    logic [ROW_W-1:0] coef_row1_reg;
    logic [ROW_W-1:0] coef_row2_reg;
    cmc_mode_t        mode_reg;

    // Input stage.
    logic             in_valid_reg;
    logic [PIX_W-1:0] in_c0_reg;
    logic [PIX_W-1:0] in_c1_reg;
    logic [PIX_W-1:0] in_c2_reg;

    // Result stage.
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_c0_reg;
    logic [PIX_W-1:0] out_c1_reg;
    logic [PIX_W-1:0] out_c2_reg;

    logic             s_take;
    logic             advance;
    logic             in_valid_next;
    logic             out_valid_next;

    cmc_diff_t        d0;
    cmc_diff_t        d1;
    cmc_diff_t        d2;
    logic [PIX_W-1:0] res_c0;
    logic [PIX_W-1:0] res_c1;
    logic [PIX_W-1:0] res_c2;

    // Write the addressed register; the index covers exactly the register list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_row0_reg <= ROW_W'(COEF_ONE);
            coef_row1_reg <= ROW_W'(COEF_ONE) << COEF_W;
            coef_row2_reg <= ROW_W'(COEF_ONE) << (2 * COEF_W);
            mode_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cmc_reg_idx_t'(cfg_addr))
                REG_COEF_ROW0:       coef_row0_reg         <= cfg_wdata;
                REG_COEF_ROW1:       coef_row1_reg         <= cfg_wdata;
                REG_COEF_ROW2:       coef_row2_reg         <= cfg_wdata;
                REG_IN_LIMITED:      mode_reg.in_limited   <= cfg_wdata[0];
                REG_OUT_LIMITED:     mode_reg.out_limited  <= cfg_wdata[0];
                REG_IN_CENTERED:     mode_reg.in_centered  <= cfg_wdata[0];
                REG_OUT_CENTERED:    mode_reg.out_centered <= cfg_wdata[0];
                REG_WIDE_COMPONENTS: mode_reg.wide         <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Advance the input word when the result register is empty or being drained.
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign s_take         = s_valid && s_ready;
    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input loads on handshake, result on advance, both hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_c0_reg <= s_in_c0;
            in_c1_reg <= s_in_c1;
            in_c2_reg <= s_in_c2;
        end
        if (advance) begin
            out_c0_reg <= res_c0;
            out_c1_reg <= res_c1;
            out_c2_reg <= res_c2;
        end
    end

    cmc_in_cond u_in_cond (
        .mode (mode_reg),
        .c0   (in_c0_reg),
        .c1   (in_c1_reg),
        .c2   (in_c2_reg),
        .d0   (d0),
        .d1   (d1),
        .d2   (d2)
    );

    // Row 0 yields luma (or red); rows 1 and 2 the chroma-side components.
    cmc_row u_row0 (
        .mode     (mode_reg),
        .luma     (1'b1),
        .coef_row (coef_row0_reg),
        .d0       (d0),
        .d1       (d1),
        .d2       (d2),
        .c_out    (res_c0)
    );

    cmc_row u_row1 (
        .mode     (mode_reg),
        .luma     (1'b0),
        .coef_row (coef_row1_reg),
        .d0       (d0),
        .d1       (d1),
        .d2       (d2),
        .c_out    (res_c1)
    );

    cmc_row u_row2 (
        .mode     (mode_reg),
        .luma     (1'b0),
        .coef_row (coef_row2_reg),
        .d0       (d0),
        .d1       (d1),
        .d2       (d2),
        .c_out    (res_c2)
    );

    assign m_valid  = out_valid_reg;
    assign m_out_c0 = out_c0_reg;
    assign m_out_c1 = out_c1_reg;
    assign m_out_c2 = out_c2_reg;

endmodule

>>> sv/cmc_in_cond.sv
`timescale 1ns / 1ps
// Input conditioning: scale each component to 24 bits, clamp, remove zero point.
module cmc_in_cond
    import cmc_pkg::*;
(
    input  cmc_mode_t        mode,
    input  logic [PIX_W-1:0] c0,
    input  logic [PIX_W-1:0] c1,
    input  logic [PIX_W-1:0] c2,
    output cmc_diff_t        d0,
    output cmc_diff_t        d1,
    output cmc_diff_t        d2
);

    logic [PIX_W-1:0] raw [3];
    cmc_diff_t        diff [3];

    assign raw[0] = c0;
    assign raw[1] = c1;
    assign raw[2] = c2;

    always_comb begin
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] lo;
        logic [COMP_W-1:0] hi;
        logic [COMP_W-1:0] zp;
        for (int j = 0; j < 3; j++) begin
            // narrow mode keeps only the low byte
            x  = mode.wide ? {raw[j], 8'h00} : {raw[j][7:0], 16'h0000};
            lo = range_min(mode.in_limited);
            hi = range_max(mode.in_limited, j == 0);
            zp = zero_point(mode.in_limited, mode.in_centered, j == 0);
            if (x < lo) begin
                x = lo;
            end else if (x > hi) begin
                x = hi;
            end
            diff[j] = $signed({1'b0, x}) - $signed({1'b0, zp});
        end
    end

    assign d0 = diff[0];
    assign d1 = diff[1];
    assign d2 = diff[2];

endmodule

>>> sv/cmc_row.sv
`timescale 1ns / 1ps
// One matrix row: three products, truncation, zero point, clamp and rescale.
module cmc_row
    import cmc_pkg::*;
(
    input  cmc_mode_t        mode,
    input  logic             luma,
    input  logic [ROW_W-1:0] coef_row,
    input  cmc_diff_t        d0,
    input  cmc_diff_t        d1,
    input  cmc_diff_t        d2,
    output logic [PIX_W-1:0] c_out
);

    cmc_diff_t               d [3];
    logic signed [QUOT_W-1:0] q [3];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lo_s;
    logic signed [SUM_W-1:0]  hi_s;
    logic signed [SUM_W-1:0]  clamped;
    logic [COMP_W-1:0]        v24;

    assign d[0] = d0;
    assign d[1] = d1;
    assign d[2] = d2;

    // Products truncated toward zero: bias negatives before the arithmetic shift.
    always_comb begin
        logic signed [COEF_W-1:0] coef;
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] p_adj;
        for (int j = 0; j < 3; j++) begin
            coef  = $signed(coef_row[COEF_W*j +: COEF_W]);
            p     = coef * d[j];
            p_adj = p + $signed({{(PROD_W-COEF_FRAC_BITS){1'b0}},
                                 {COEF_FRAC_BITS{p[PROD_W-1]}}});
            q[j]  = QUOT_W'(p_adj >>> COEF_FRAC_BITS);
        end
    end

    always_comb begin
        sum  = $signed(SUM_W'(zero_point(mode.out_limited, mode.out_centered, luma)))
             + SUM_W'(q[0]) + SUM_W'(q[1]) + SUM_W'(q[2]);
        lo_s = $signed(SUM_W'(range_min(mode.out_limited)));
        hi_s = $signed(SUM_W'(range_max(mode.out_limited, luma)));
        if (sum < lo_s) begin
            clamped = lo_s;
        end else if (sum > hi_s) begin
            clamped = hi_s;
        end else begin
            clamped = sum;
        end
    end

    assign v24   = clamped[COMP_W-1:0];
    assign c_out = mode.wide ? v24[COMP_W-1:8] : {8'h00, v24[COMP_W-1:16]};

endmodule

>>> sv/cmc_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the colour matrix converter, bound to the top level.
module cmc_checker
    import cmc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_wr_en,
    input logic [CFG_IDX_W-1:0] cfg_addr,
    input logic [ROW_W-1:0]     cfg_wdata,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [PIX_W-1:0]     m_out_c0,
    input logic [PIX_W-1:0]     m_out_c1,
    input logic [PIX_W-1:0]     m_out_c2
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       wide_reg;
    logic       s_take;
    logic       m_take;

    assign s_take = s_valid && s_ready;
    assign m_take = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (s_take && !m_take) begin
            pending_next = pending_reg + 2'd1;
        end else if (m_take && !s_take) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    // Count pending words and mirror the component-width setting from the write port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            wide_reg    <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            if (cfg_wr_en && cfg_addr == REG_WIDE_COMPONENTS) begin
                wide_reg <= cfg_wdata[0];
            end
        end
    end

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_c0)
                               && $stable(m_out_c1) && $stable(m_out_c2))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result without a pending input word");

    a_two_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd2 && !m_ready |-> !s_ready)
        else $error("input taken with both stages full");

    a_narrow_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !wide_reg |-> m_out_c0[15:8] == 8'h00 && m_out_c1[15:8] == 8'h00
                                 && m_out_c2[15:8] == 8'h00)
        else $error("upper byte set in 8-bit mode");

endmodule

bind color_matrix_converter cmc_checker u_cmc_checker (.*);
